// File: sv/pmb_pkg.sv
// Package: shared types and constants of the predictive pressure blend unit.
package pmb_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int DIV_STEPS   = 16;
  localparam int STEP_W      = $clog2(DIV_STEPS);

  // Item class decided at the front
  typedef enum logic [1:0] {
    OP_TICK,
    OP_PASS,
    OP_PRED
  } op_t;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL,
    BK_DIV,
    BK_FIN
  } bk_state_t;

  // Classified item held in the queue; for OP_PASS, pressure is the value to give
  typedef struct packed {
    op_t         op;
    logic [15:0] pressure;
    logic [15:0] table_pressure;
    logic [15:0] blend_ticks;
    logic        accel_event;
    logic        above_threshold;
  } q_item_t;

  // Queue fill status
  typedef struct packed {
    logic not_empty;
    logic not_full;
  } q_stat_t;

endpackage

// File: sv/pmb_in_if.sv
// Interface: input item channel.
interface pmb_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] sensor_pressure;
  logic        sensor_valid;
  logic [15:0] table_pressure;
  logic [15:0] blend_ticks;
  logic        accel_event;
  logic        above_threshold;

  modport source (
    output valid, kind, sensor_pressure, sensor_valid, table_pressure,
           blend_ticks, accel_event, above_threshold,
    input  ready
  );
  modport sink (
    input  valid, kind, sensor_pressure, sensor_valid, table_pressure,
           blend_ticks, accel_event, above_threshold,
    output ready
  );
endinterface

// File: sv/pmb_out_if.sv
// Interface: result item channel.
interface pmb_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] effective_pressure;
  logic        predicting;
  logic        event_taken;
  logic        restart_accel_timer;
  logic [15:0] end_count;
  logic [15:0] start_count;

  modport source (
    output valid, effective_pressure, predicting, event_taken,
           restart_accel_timer, end_count, start_count,
    input  ready
  );
  modport sink (
    input  valid, effective_pressure, predicting, event_taken,
           restart_accel_timer, end_count, start_count,
    output ready
  );
endinterface

// File: sv/pmb_cfg_if.sv
// Interface: configuration write channel.
interface pmb_cfg_if;
  logic valid;
  logic ready;
  logic predictive_enable;

  modport source (output valid, predictive_enable, input ready);
  modport sink (input valid, predictive_enable, output ready);
endinterface

// File: sv/predictive_map_blend_unit.sv
// Predictive manifold pressure blend unit: top level.
//
// Channels: req carries input items (kind 0 is a timer tick, kind 1 an
// evaluate); rsp returns one result item per evaluate, none per tick; cfg
// writes the predictive_enable bit and is always ready. All use valid/ready,
// an item moving on a clock edge with both high.
// Accepted items enter a four-entry queue, so req stays ready while the
// queue has room, even while a result waits on rsp.
// Back-end steps: a tick, a plain evaluate, or an evaluate that starts a
// prediction or ends it on duration is handled in the cycle that takes it
// from the queue, and its result is registered. A predictive evaluate during
// an active blend holds the back end: the cycle that takes it from the
// queue, a multiply state, the steps of the one-bit-per-cycle divider that
// forms the blend factor, and a finishing state that registers its result.
// Sustained rate: one item per cycle for ticks and plain evaluates while rsp
// does not stall; while blending, the back end takes no new item until the
// blend finishes.
// Reset (rst, synchronous) clears the blend state, counters, queue and mode.
// When rsp stalls, the back end stops taking items from the queue; the front
// keeps accepting until the queue fills.
module predictive_map_blend_unit (
  input  logic      clk,
  input  logic      rst,
  pmb_in_if.sink    req,
  pmb_cfg_if.sink   cfg,
  pmb_out_if.source rsp
);
  import pmb_pkg::*;

  q_stat_t stat;
  q_item_t push_item;
  q_item_t head;
  logic    push;
  logic    pop;

  pmb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg       (cfg),
    .stat      (stat),
    .push      (push),
    .push_item (push_item)
  );

  pmb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .stat      (stat)
  );

  pmb_back u_back (
    .clk  (clk),
    .rst  (rst),
    .head (head),
    .stat (stat),
    .pop  (pop),
    .rsp  (rsp)
  );

endmodule

// File: sv/pmb_front.sv
// Front end: accepts items, holds the mode register and classifies each item.
module pmb_front (
  input  logic            clk,
  input  logic            rst,
  pmb_in_if.sink          req,
  pmb_cfg_if.sink         cfg,
  input  pmb_pkg::q_stat_t stat,
  output logic            push,
  output pmb_pkg::q_item_t push_item
);
  import pmb_pkg::*;

  logic predictive_enable;

  // Store the mode bit on each write
  always_ff @(posedge clk) begin
    if (rst) begin
      predictive_enable <= 1'b0;
    end else if (cfg.valid) begin
      predictive_enable <= cfg.predictive_enable;
    end
  end

  assign cfg.ready = 1'b1;
  assign req.ready = stat.not_full;
  assign push      = req.valid && stat.not_full;

  // Classify: tick, plain pass-through, or predictive evaluate
  always_comb begin
    push_item.table_pressure  = req.table_pressure;
    push_item.blend_ticks     = req.blend_ticks;
    push_item.accel_event     = req.accel_event;
    push_item.above_threshold = req.above_threshold;
    push_item.pressure        = req.sensor_pressure;
    if (!req.kind) begin
      push_item.op = OP_TICK;
    end else if (!req.sensor_valid) begin
      push_item.op       = OP_PASS;
      push_item.pressure = req.table_pressure;
    end else if (!predictive_enable) begin
      push_item.op = OP_PASS;
    end else begin
      push_item.op = OP_PRED;
    end
  end

endmodule

// File: sv/pmb_queue.sv
// Queue: short FIFO of classified items between front and back.
module pmb_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  pmb_pkg::q_item_t push_item,
  input  logic             pop,
  output pmb_pkg::q_item_t head,
  output pmb_pkg::q_stat_t stat
);
  import pmb_pkg::*;

  q_item_t            entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign stat.not_empty = (count != '0);
  assign stat.not_full  = (count != CNT_W'(QUEUE_DEPTH));
  assign do_push        = push && stat.not_full;
  assign do_pop         = pop && stat.not_empty;
  assign head           = entries[rd_ptr];

  // Write the entry
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count != CNT_W'(QUEUE_DEPTH) && count != '0) |-> (wr_ptr != rd_ptr))
    else $error("queue pointers disagree with count");
  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> stat.not_empty)
    else $error("pop from empty queue");
`endif

endmodule

// File: sv/pmb_back.sv
// Back end: blend state, multiply and shift-subtract divide, result register.
module pmb_back (
  input  logic             clk,
  input  logic             rst,
  input  pmb_pkg::q_item_t head,
  input  pmb_pkg::q_stat_t stat,
  output logic             pop,
  pmb_out_if.source        rsp
);
  import pmb_pkg::*;

  bk_state_t         state, state_next;
  logic              active, active_next;
  logic              await_rel, await_rel_next;
  logic [15:0]       base, base_next;
  logic [15:0]       elapsed, elapsed_next;
  logic [15:0]       ended_total, ended_total_next;
  logic [15:0]       started_total, started_total_next;
  logic [15:0]       w_sensor, w_sensor_next;
  logic [15:0]       w_blend, w_blend_next;
  logic              neg, neg_next;
  logic [15:0]       rem, rem_next;
  logic [15:0]       quot, quot_next;
  logic [STEP_W-1:0] step, step_next;
  logic              out_valid, out_valid_next;
  logic [15:0]       o_eff, o_eff_next;
  logic              o_pred, o_pred_next;
  logic              o_taken, o_taken_next;
  logic              o_restart, o_restart_next;
  logic [15:0]       o_end, o_end_next;
  logic [15:0]       o_start, o_start_next;

  logic              out_free;
  logic              act1;
  logic              await1;
  logic [15:0]       mag;
  logic [31:0]       prod;
  logic [16:0]       trial;
  logic [17:0]       q_signed;
  logic [17:0]       value;

  assign out_free = !out_valid || rsp.ready;
  assign pop      = (state == BK_IDLE) && stat.not_empty && out_free;

  // Sequencer and state update
  always_comb begin
    state_next         = state;
    active_next        = active;
    await_rel_next     = await_rel;
    base_next          = base;
    elapsed_next       = elapsed;
    ended_total_next   = ended_total;
    started_total_next = started_total;
    w_sensor_next      = w_sensor;
    w_blend_next       = w_blend;
    neg_next           = neg;
    rem_next           = rem;
    quot_next          = quot;
    step_next          = step;
    out_valid_next     = out_valid && !rsp.ready;
    o_eff_next         = o_eff;
    o_pred_next        = o_pred;
    o_taken_next       = o_taken;
    o_restart_next     = o_restart;
    o_end_next         = o_end;
    o_start_next       = o_start;
    act1               = 1'b0;
    await1             = 1'b0;
    mag                = '0;
    prod               = '0;
    trial              = '0;
    q_signed           = '0;
    value              = '0;

    case (state)
      BK_IDLE: begin
        if (pop) begin
          case (head.op)
            OP_TICK: begin
              if (elapsed != 16'hFFFF) begin
                elapsed_next = elapsed + 16'd1;
              end
            end
            OP_PASS: begin
              out_valid_next = 1'b1;
              o_eff_next     = head.pressure;
              o_pred_next    = active;
              o_taken_next   = 1'b0;
              o_restart_next = 1'b0;
              o_end_next     = ended_total;
              o_start_next   = started_total;
            end
            OP_PRED: begin
              // End the blend once its duration has run out
              act1 = active && (elapsed < head.blend_ticks);
              if (active && !act1) begin
                ended_total_next = ended_total + 16'd1;
              end
              await1         = await_rel && head.above_threshold;
              active_next    = act1;
              await_rel_next = await1;
              o_eff_next     = head.pressure;
              o_taken_next   = 1'b0;
              o_restart_next = 1'b0;
              if (act1) begin
                // Adopt a higher prediction and restart the blend
                if (head.table_pressure > base) begin
                  base_next    = head.table_pressure;
                  elapsed_next = '0;
                end
                w_sensor_next = head.pressure;
                w_blend_next  = head.blend_ticks;
                state_next    = BK_MUL;
              end else begin
                if (!await1 && head.accel_event) begin
                  o_taken_next = 1'b1;
                  if (head.table_pressure > head.pressure) begin
                    active_next        = 1'b1;
                    o_restart_next     = 1'b1;
                    elapsed_next       = '0;
                    base_next          = head.table_pressure;
                    started_total_next = started_total + 16'd1;
                    await_rel_next     = 1'b1;
                    o_eff_next         = head.table_pressure;
                  end
                end
                out_valid_next = 1'b1;
                o_pred_next    = active_next;
                o_end_next     = ended_total_next;
                o_start_next   = started_total_next;
              end
            end
            default: begin
              state_next = BK_IDLE;
            end
          endcase
        end
      end
      BK_MUL: begin
        // Magnitude of the gap times the elapsed ticks
        neg_next  = w_sensor < base;
        mag       = (w_sensor < base) ? (base - w_sensor) : (w_sensor - base);
        prod      = mag * elapsed;
        rem_next  = prod[31:16];
        quot_next = prod[15:0];
        step_next = '0;
        state_next = BK_DIV;
      end
      BK_DIV: begin
        // One quotient bit per cycle
        trial = {rem, quot[15]};
        if (trial >= {1'b0, w_blend}) begin
          rem_next  = 16'(trial - {1'b0, w_blend});
          quot_next = {quot[14:0], 1'b1};
        end else begin
          rem_next  = trial[15:0];
          quot_next = {quot[14:0], 1'b0};
        end
        step_next = step + 1'b1;
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          state_next = BK_FIN;
        end
      end
      BK_FIN: begin
        // Apply the signed step and stop once the sensor catches up
        q_signed = neg ? (18'd0 - {2'b00, quot}) : {2'b00, quot};
        value    = {2'b00, base} + q_signed;
        if ($signed({2'b00, w_sensor}) >= $signed(value)) begin
          active_next = 1'b0;
          o_eff_next  = w_sensor;
        end else begin
          o_eff_next  = value[15:0];
        end
        out_valid_next = 1'b1;
        o_pred_next    = active_next;
        o_taken_next   = 1'b1;
        o_restart_next = 1'b0;
        o_end_next     = ended_total;
        o_start_next   = started_total;
        state_next     = BK_IDLE;
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= BK_IDLE;
      active        <= 1'b0;
      await_rel     <= 1'b0;
      base          <= '0;
      elapsed       <= '0;
      ended_total   <= '0;
      started_total <= '0;
      out_valid     <= 1'b0;
      step          <= '0;
    end else begin
      state         <= state_next;
      active        <= active_next;
      await_rel     <= await_rel_next;
      base          <= base_next;
      elapsed       <= elapsed_next;
      ended_total   <= ended_total_next;
      started_total <= started_total_next;
      out_valid     <= out_valid_next;
      step          <= step_next;
    end
  end

  // Hold working and result payload
  always_ff @(posedge clk) begin
    w_sensor  <= w_sensor_next;
    w_blend   <= w_blend_next;
    neg       <= neg_next;
    rem       <= rem_next;
    quot      <= quot_next;
    o_eff     <= o_eff_next;
    o_pred    <= o_pred_next;
    o_taken   <= o_taken_next;
    o_restart <= o_restart_next;
    o_end     <= o_end_next;
    o_start   <= o_start_next;
  end

  assign rsp.valid               = out_valid;
  assign rsp.effective_pressure  = o_eff;
  assign rsp.predicting          = o_pred;
  assign rsp.event_taken         = o_taken;
  assign rsp.restart_accel_timer = o_restart;
  assign rsp.end_count           = o_end;
  assign rsp.start_count         = o_start;

`ifndef NO_ASSERTIONS
  a_fin_slot_free: assert property (@(posedge clk) disable iff (rst)
    (state == BK_FIN) |-> !out_valid)
    else $error("result register busy when blend finishes");
  a_busy_active: assert property (@(posedge clk) disable iff (rst)
    (state != BK_IDLE) |-> active)
    else $error("blend running without an active prediction");
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == BK_DIV) |-> (rem < w_blend))
    else $error("divider remainder out of range");
  a_mul_to_div: assert property (@(posedge clk) disable iff (rst)
    (state == BK_MUL) |=> (state == BK_DIV && step == '0))
    else $error("divider did not start cleanly");
`endif

endmodule
